// File: hdl/ffa_pkg.sv
// Shared types and codes for the first-fit arena allocator.
// Used by ffa_ctrl, ffa_dp and the top level; no dependencies.
package ffa_pkg;

  localparam int unsigned FIELD_W = 17;

  typedef enum logic [1:0] {
    FUNC_ALLOC,
    FUNC_FREE,
    FUNC_REALLOC,
    FUNC_REINIT
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_NO_SPACE,
    ST_NOT_FOUND,
    ST_TABLE_FULL
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_RI1,
    S_ASCAN,
    S_SHUP,
    S_AWR,
    S_FSCAN,
    S_RCHK,
    S_RRD,
    S_SHDN,
    S_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RESULT,
    OP_REINIT0,
    OP_REINIT1,
    OP_ASTART,
    OP_ASCAN,
    OP_SHUP,
    OP_AWRITE,
    OP_FSTART,
    OP_FSCAN,
    OP_RCHECK,
    OP_RREAD,
    OP_SHDN,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e st;
    logic    mv;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  null_ptr;
    logic  sentinel;
    logic  size_zero;
    logic  cnt_lt2;
    logic  cnt_lt3;
    logic  full;
    logic  fit;
    logic  scan_last;
    logic  match;
    logic  find_last;
    logic  keep;
    logic  sh_end;
    logic  dn_end;
    logic  mv;
    logic  out_free;
  } sts_t;

endpackage

// File: hdl/ffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffa_ram #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/ffa_ctrl.sv
// Request sequencer of the first-fit arena allocator.
// Depends on ffa_pkg; drives ffa_dp through cmd_t, reads sts_t.
module ffa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ffa_pkg::sts_t sts_i,
  output ffa_pkg::cmd_t cmd_o
);

  ffa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ffa_pkg::S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ffa_pkg::S_IDLE: begin
        if (in_valid_i) state_d = ffa_pkg::S_DEC;
      end
      ffa_pkg::S_DEC: begin
        state_d = ffa_pkg::S_OUT;
        unique case (sts_i.func)
          ffa_pkg::FUNC_ALLOC: begin
            if (!sts_i.size_zero && !sts_i.cnt_lt2) state_d = ffa_pkg::S_ASCAN;
          end
          ffa_pkg::FUNC_FREE: begin
            if (!sts_i.null_ptr && !sts_i.sentinel && !sts_i.cnt_lt3) begin
              state_d = ffa_pkg::S_FSCAN;
            end
          end
          ffa_pkg::FUNC_REALLOC: begin
            if (!sts_i.sentinel && !sts_i.size_zero) begin
              if (sts_i.null_ptr) begin
                if (!sts_i.cnt_lt2) state_d = ffa_pkg::S_ASCAN;
              end else if (!sts_i.cnt_lt3) begin
                state_d = ffa_pkg::S_FSCAN;
              end
            end
          end
          ffa_pkg::FUNC_REINIT: state_d = ffa_pkg::S_RI1;
          default: state_d = ffa_pkg::S_OUT;
        endcase
      end
      ffa_pkg::S_RI1: state_d = ffa_pkg::S_OUT;
      ffa_pkg::S_ASCAN: begin
        if (sts_i.fit) begin
          state_d = sts_i.full ? ffa_pkg::S_OUT : ffa_pkg::S_SHUP;
        end else if (sts_i.scan_last) begin
          state_d = ffa_pkg::S_OUT;
        end
      end
      ffa_pkg::S_SHUP: begin
        if (sts_i.sh_end) state_d = ffa_pkg::S_AWR;
      end
      ffa_pkg::S_AWR: state_d = sts_i.mv ? ffa_pkg::S_RRD : ffa_pkg::S_OUT;
      ffa_pkg::S_FSCAN: begin
        if (sts_i.match) begin
          state_d = (sts_i.func == ffa_pkg::FUNC_FREE) ? ffa_pkg::S_RRD : ffa_pkg::S_RCHK;
        end else if (sts_i.find_last) begin
          state_d = ffa_pkg::S_OUT;
        end
      end
      ffa_pkg::S_RCHK: state_d = sts_i.keep ? ffa_pkg::S_OUT : ffa_pkg::S_ASCAN;
      ffa_pkg::S_RRD: state_d = ffa_pkg::S_SHDN;
      ffa_pkg::S_SHDN: begin
        if (sts_i.dn_end) state_d = ffa_pkg::S_OUT;
      end
      ffa_pkg::S_OUT: begin
        if (sts_i.out_free) state_d = ffa_pkg::S_IDLE;
      end
      default: state_d = ffa_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op = ffa_pkg::OP_NONE;
    cmd_o.st = ffa_pkg::ST_NOT_FOUND;
    cmd_o.mv = 1'b0;
    unique case (state_q)
      ffa_pkg::S_IDLE: begin
        if (in_valid_i) cmd_o.op = ffa_pkg::OP_LOAD;
      end
      ffa_pkg::S_DEC: begin
        cmd_o.op = ffa_pkg::OP_RESULT;
        unique case (sts_i.func)
          ffa_pkg::FUNC_ALLOC: begin
            if (sts_i.size_zero) begin
              cmd_o.st = ffa_pkg::ST_NOT_FOUND;
            end else if (sts_i.cnt_lt2) begin
              cmd_o.st = ffa_pkg::ST_NO_SPACE;
            end else begin
              cmd_o.op = ffa_pkg::OP_ASTART;
            end
          end
          ffa_pkg::FUNC_FREE: begin
            if (!sts_i.null_ptr && !sts_i.sentinel && !sts_i.cnt_lt3) begin
              cmd_o.op = ffa_pkg::OP_FSTART;
            end
          end
          ffa_pkg::FUNC_REALLOC: begin
            if (!sts_i.sentinel && !sts_i.size_zero) begin
              if (sts_i.null_ptr) begin
                if (sts_i.cnt_lt2) cmd_o.st = ffa_pkg::ST_NO_SPACE;
                else cmd_o.op = ffa_pkg::OP_ASTART;
              end else if (!sts_i.cnt_lt3) begin
                cmd_o.op = ffa_pkg::OP_FSTART;
              end
            end
          end
          ffa_pkg::FUNC_REINIT: cmd_o.op = ffa_pkg::OP_REINIT0;
          default: cmd_o.op = ffa_pkg::OP_RESULT;
        endcase
      end
      ffa_pkg::S_RI1: cmd_o.op = ffa_pkg::OP_REINIT1;
      ffa_pkg::S_ASCAN: begin
        if (sts_i.fit && sts_i.full) begin
          cmd_o.op = ffa_pkg::OP_RESULT;
          cmd_o.st = ffa_pkg::ST_TABLE_FULL;
        end else if (!sts_i.fit && sts_i.scan_last) begin
          cmd_o.op = ffa_pkg::OP_RESULT;
          cmd_o.st = ffa_pkg::ST_NO_SPACE;
        end else begin
          cmd_o.op = ffa_pkg::OP_ASCAN;
        end
      end
      ffa_pkg::S_SHUP: cmd_o.op = ffa_pkg::OP_SHUP;
      ffa_pkg::S_AWR: cmd_o.op = ffa_pkg::OP_AWRITE;
      ffa_pkg::S_FSCAN: begin
        if (!sts_i.match && sts_i.find_last) begin
          cmd_o.op = ffa_pkg::OP_RESULT;
        end else begin
          cmd_o.op = ffa_pkg::OP_FSCAN;
        end
      end
      ffa_pkg::S_RCHK: cmd_o.op = ffa_pkg::OP_RCHECK;
      ffa_pkg::S_RRD: cmd_o.op = ffa_pkg::OP_RREAD;
      ffa_pkg::S_SHDN: cmd_o.op = ffa_pkg::OP_SHDN;
      ffa_pkg::S_OUT: begin
        if (sts_i.out_free) cmd_o.op = ffa_pkg::OP_EMIT;
      end
      default: cmd_o.op = ffa_pkg::OP_NONE;
    endcase
  end

endmodule

// File: hdl/ffa_dp.sv
// Datapath of the first-fit arena allocator: block table RAM, scan
// registers, gap arithmetic and output register. Depends on ffa_pkg, ffa_ram.
module ffa_dp #(
  parameter int unsigned ARENA_BYTES  = 65536,
  parameter int unsigned HEADER_BYTES = 12,
  parameter int unsigned MAX_BLOCKS   = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [1:0]                  func_i,
  input  logic [ffa_pkg::FIELD_W-1:0] addr_i,
  input  logic                        addr_null_i,
  input  logic [ffa_pkg::FIELD_W-1:0] req_size_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ffa_pkg::FIELD_W-1:0] result_addr_o,
  output logic                        granted_o,
  output logic [1:0]                  status_o,
  output logic [ffa_pkg::FIELD_W-1:0] copy_from_o,
  output logic [ffa_pkg::FIELD_W-1:0] copy_len_o,
  input  ffa_pkg::cmd_t               cmd_i,
  output ffa_pkg::sts_t               sts_o
);

  localparam int unsigned FW = ffa_pkg::FIELD_W;
  localparam int unsigned AW = $clog2(ARENA_BYTES + 1);
  localparam int unsigned SW = (AW > FW) ? AW : FW;
  localparam int unsigned DW = SW + 2;
  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

  localparam logic [SW-1:0] HEAD_START = SW'(HEADER_BYTES);
  localparam logic [SW-1:0] ARENA_END  = SW'(ARENA_BYTES);

  // request
  ffa_pkg::func_e func_q;
  logic [FW-1:0]  addr_q, size_q;
  logic           null_q, mv_q;
  // table walk
  logic [CW-1:0]  cnt_q, j_q, k_q, p_q;
  logic [SW-1:0]  prv_s_q, prv_l_q, ol_q;
  // working result and output register
  logic [FW-1:0]  res_addr_q, res_cf_q, res_cl_q;
  logic           res_g_q;
  ffa_pkg::status_e res_st_q;
  logic           out_valid_q;

  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [2*SW-1:0] ram_wdata, ram_rdata;

  ffa_ram #(
    .WIDTH (2 * SW),
    .DEPTH (MAX_BLOCKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic [SW-1:0] rd_s, rd_l, size_x, addr_x, new_start;
  logic [CW-1:0] j_inc, j_dec, cnt_dec, k_inc;
  logic [CW:0]   j_inc2;
  logic [DW-1:0] fit_sum, room_sum;
  logic          fits, room, same, keep, fit;
  logic [FW-1:0] clen;

  assign rd_s      = ram_rdata[2*SW-1:SW];
  assign rd_l      = ram_rdata[SW-1:0];
  assign size_x    = SW'(size_q);
  assign addr_x    = SW'(addr_q);
  assign j_inc     = j_q + CW'(1);
  assign j_dec     = j_q - CW'(1);
  assign j_inc2    = (CW+1)'(j_q) + (CW+1)'(2);
  assign cnt_dec   = cnt_q - CW'(1);
  assign k_inc     = k_q + CW'(1);
  assign fit_sum   = DW'(prv_s_q) + DW'(prv_l_q) + DW'(size_x) + DW'(2 * HEADER_BYTES);
  assign room_sum  = DW'(prv_s_q) + DW'(size_x) + DW'(HEADER_BYTES);
  assign new_start = SW'(DW'(prv_s_q) + DW'(prv_l_q) + DW'(HEADER_BYTES));
  assign fits      = (fit_sum <= DW'(rd_s));
  assign room      = (room_sum <= DW'(rd_s));
  assign same      = (size_x == prv_l_q);
  assign keep      = same || room;
  assign fit       = (j_q != '0) && fits;
  assign clen      = (size_x <= ol_q) ? size_q : FW'(ol_q);

  always_comb begin
    sts_o.func      = func_q;
    sts_o.null_ptr  = null_q;
    sts_o.sentinel  = !null_q && ((addr_x == '0) || (addr_x == ARENA_END));
    sts_o.size_zero = (size_q == '0);
    sts_o.cnt_lt2   = (cnt_q < CW'(2));
    sts_o.cnt_lt3   = (cnt_q < CW'(3));
    sts_o.full      = (cnt_q >= CW'(MAX_BLOCKS));
    sts_o.fit       = fit;
    sts_o.scan_last = (j_inc >= cnt_q);
    sts_o.match     = (rd_s == addr_x);
    sts_o.find_last = (j_inc2 >= (CW+1)'(cnt_q));
    sts_o.keep      = keep;
    sts_o.sh_end    = (j_q == p_q);
    sts_o.dn_end    = (j_q == cnt_dec);
    sts_o.mv        = mv_q;
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  // table port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (cmd_i.op)
      ffa_pkg::OP_REINIT0: begin
        ram_we    = 1'b1;
        ram_wdata = {HEAD_START, SW'(0)};
      end
      ffa_pkg::OP_REINIT1: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(1);
        ram_wdata = {ARENA_END, SW'(0)};
      end
      ffa_pkg::OP_ASCAN: begin
        // on a fit, start the upward shift from the top entry
        ram_raddr = fit ? cnt_dec[IW-1:0] : j_inc[IW-1:0];
      end
      ffa_pkg::OP_SHUP: begin
        ram_we    = 1'b1;
        ram_waddr = j_inc[IW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = j_dec[IW-1:0];
      end
      ffa_pkg::OP_AWRITE: begin
        ram_we    = 1'b1;
        ram_waddr = p_q[IW-1:0];
        ram_wdata = {new_start, size_x};
      end
      ffa_pkg::OP_FSTART: ram_raddr = IW'(1);
      ffa_pkg::OP_FSCAN:  ram_raddr = j_inc[IW-1:0];
      ffa_pkg::OP_RCHECK: begin
        if (keep && !same) begin
          ram_we    = 1'b1;
          ram_waddr = k_q[IW-1:0];
          ram_wdata = {prv_s_q, size_x};
        end
      end
      ffa_pkg::OP_RREAD: ram_raddr = k_inc[IW-1:0];
      ffa_pkg::OP_SHDN: begin
        ram_we    = 1'b1;
        ram_waddr = j_dec[IW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = j_inc[IW-1:0];
      end
      default: ram_raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == ffa_pkg::OP_REINIT1) begin
        cnt_q <= CW'(2);
      end else if (cmd_i.op == ffa_pkg::OP_AWRITE) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.op == ffa_pkg::OP_SHDN && sts_o.dn_end) begin
        cnt_q <= cnt_dec;
      end
      if (cmd_i.op == ffa_pkg::OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      ffa_pkg::OP_LOAD: begin
        func_q <= ffa_pkg::func_e'(func_i);
        addr_q <= addr_i;
        null_q <= addr_null_i;
        size_q <= req_size_i;
        mv_q   <= 1'b0;
      end
      ffa_pkg::OP_RESULT: begin
        res_addr_q <= '0;
        res_g_q    <= 1'b0;
        res_st_q   <= cmd_i.st;
        res_cf_q   <= '0;
        res_cl_q   <= '0;
      end
      ffa_pkg::OP_REINIT1: begin
        res_addr_q <= '0;
        res_g_q    <= 1'b0;
        res_st_q   <= ffa_pkg::ST_DONE;
        res_cf_q   <= '0;
        res_cl_q   <= '0;
      end
      ffa_pkg::OP_ASTART: begin
        j_q  <= '0;
        mv_q <= cmd_i.mv;
      end
      ffa_pkg::OP_ASCAN: begin
        if (fit) begin
          p_q <= j_q;
          j_q <= cnt_dec;
        end else begin
          prv_s_q <= rd_s;
          prv_l_q <= rd_l;
          j_q     <= j_inc;
        end
      end
      ffa_pkg::OP_SHUP: j_q <= j_dec;
      ffa_pkg::OP_AWRITE: begin
        res_addr_q <= new_start[FW-1:0];
        res_g_q    <= 1'b1;
        res_st_q   <= ffa_pkg::ST_DONE;
        res_cf_q   <= mv_q ? addr_q : '0;
        res_cl_q   <= mv_q ? clen : '0;
        // the old block moved up if the new one went in below it
        if (p_q <= k_q) k_q <= k_inc;
      end
      ffa_pkg::OP_FSTART: j_q <= CW'(1);
      ffa_pkg::OP_FSCAN: begin
        if (sts_o.match) begin
          k_q     <= j_q;
          prv_s_q <= rd_s;
          prv_l_q <= rd_l;
          ol_q    <= rd_l;
        end else begin
          j_q <= j_inc;
        end
      end
      ffa_pkg::OP_RCHECK: begin
        if (keep) begin
          res_addr_q <= addr_q;
          res_g_q    <= 1'b1;
          res_st_q   <= ffa_pkg::ST_DONE;
          res_cf_q   <= '0;
          res_cl_q   <= '0;
        end else begin
          j_q  <= '0;
          mv_q <= 1'b1;
        end
      end
      ffa_pkg::OP_RREAD: j_q <= k_inc;
      ffa_pkg::OP_SHDN: begin
        j_q <= j_inc;
        if (sts_o.dn_end && !mv_q) begin
          res_addr_q <= '0;
          res_g_q    <= 1'b0;
          res_st_q   <= ffa_pkg::ST_DONE;
          res_cf_q   <= '0;
          res_cl_q   <= '0;
        end
      end
      ffa_pkg::OP_EMIT: begin
        result_addr_o <= res_addr_q;
        granted_o     <= res_g_q;
        status_o      <= res_st_q;
        copy_from_o   <= res_cf_q;
        copy_len_o    <= res_cl_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/first_fit_arena_allocator_top.sv
// Handles one request at a time and walks the block table in RAM, one entry
// per cycle. Allocate scans the entries up to the fitting gap and then shifts
// entries up to open the slot (tail included); free looks the block up among
// the entries in use and shifts the later ones down. A moving reallocation
// runs the lookup, an allocate and the free in a row. The single read and
// single write port of the table RAM set this pace. The result sits in an
// output register, so the next request is taken while it waits.
// Depends on ffa_pkg, ffa_ctrl, ffa_dp and ffa_ram.
module first_fit_arena_allocator_top #(
  parameter int unsigned ARENA_BYTES  = 65536,
  parameter int unsigned HEADER_BYTES = 12,
  parameter int unsigned MAX_BLOCKS   = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  func_i,
  input  logic [ffa_pkg::FIELD_W-1:0] addr_i,
  input  logic                        addr_null_i,
  input  logic [ffa_pkg::FIELD_W-1:0] req_size_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ffa_pkg::FIELD_W-1:0] result_addr_o,
  output logic                        granted_o,
  output logic [1:0]                  status_o,
  output logic [ffa_pkg::FIELD_W-1:0] copy_from_o,
  output logic [ffa_pkg::FIELD_W-1:0] copy_len_o
);

  ffa_pkg::cmd_t cmd;
  ffa_pkg::sts_t sts;

  ffa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffa_dp #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .func_i        (func_i),
    .addr_i        (addr_i),
    .addr_null_i   (addr_null_i),
    .req_size_i    (req_size_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_addr_o (result_addr_o),
    .granted_o     (granted_o),
    .status_o      (status_o),
    .copy_from_o   (copy_from_o),
    .copy_len_o    (copy_len_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule
